// ===== rtl/rfpt_pkg.sv =====
package rfpt_pkg;

	localparam int TS_W    = 42;
	localparam int WORD_W  = 32;
	localparam int KIND_W  = 2;
	localparam int DIV_W   = 64;

	// 1342177280 * 65536, Q16.16 period numerator
	localparam logic [DIV_W-1:0] PERIOD_NUM = 64'd1342177280 << 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD  = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_CORDIC,
		ST_MUL,
		ST_STORE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_MOD,
		ST_WRAP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic div_for_mod;
		logic cordic_start;
		logic mul;
		logic store;
		logic scan_clr;
		logic scan_rd;
		logic scan_adv;
		logic hit;
		logic wrap;
		logic clear;
		logic miss;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  load_ok;
		logic  div_done;
		logic  cordic_done;
		logic  scan_end;
		logic  bracket;
	} sts_t;

	function automatic logic [WORD_W-1:0] atan_turns(input logic [4:0] i);
		case (i)
			5'd0:  atan_turns = 32'h20000000;
			5'd1:  atan_turns = 32'h12E4051E;
			5'd2:  atan_turns = 32'h09FB385B;
			5'd3:  atan_turns = 32'h051111D4;
			5'd4:  atan_turns = 32'h028B0D43;
			5'd5:  atan_turns = 32'h0145D7E1;
			5'd6:  atan_turns = 32'h00A2F61E;
			5'd7:  atan_turns = 32'h00517C55;
			5'd8:  atan_turns = 32'h0028BE53;
			5'd9:  atan_turns = 32'h00145F2F;
			5'd10: atan_turns = 32'h000A2F98;
			5'd11: atan_turns = 32'h000517CC;
			5'd12: atan_turns = 32'h00028BE6;
			5'd13: atan_turns = 32'h000145F3;
			5'd14: atan_turns = 32'h0000A2F9;
			5'd15: atan_turns = 32'h0000517C;
			5'd16: atan_turns = 32'h000028BE;
			5'd17: atan_turns = 32'h0000145F;
			5'd18: atan_turns = 32'h00000A2F;
			5'd19: atan_turns = 32'h00000517;
			5'd20: atan_turns = 32'h0000028B;
			5'd21: atan_turns = 32'h00000145;
			5'd22: atan_turns = 32'h000000A2;
			5'd23: atan_turns = 32'h00000051;
			5'd24: atan_turns = 32'h00000028;
			5'd25: atan_turns = 32'h00000014;
			5'd26: atan_turns = 32'h0000000A;
			5'd27: atan_turns = 32'h00000005;
			5'd28: atan_turns = 32'h00000002;
			5'd29: atan_turns = 32'h00000001;
			default: atan_turns = 32'h00000000;
		endcase
	endfunction

endpackage

// ===== rtl/rfpt_div.sv =====
module rfpt_div
	import rfpt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quot,
	output logic [WORD_W-1:0] rem
);
	// restoring division, one quotient bit a cycle
	logic [6:0]        cnt_q;
	logic              busy_q;
	logic [DIV_W-1:0]  quot_q;
	logic [WORD_W:0]   rem_q;
	logic [WORD_W-1:0] dsr_q;
	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   diff;

	assign shifted = {rem_q[WORD_W-1:0], quot_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			if (!diff[WORD_W]) begin
				rem_q  <= diff;
				quot_q <= {quot_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				quot_q <= {quot_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == 7'd0) ? 1'b0 : (!busy_q && cnt_q == 7'd0);
	assign quot = quot_q;
	assign rem  = rem_q[WORD_W-1:0];
endmodule

// ===== rtl/rfpt_datapath.sv =====
module rfpt_datapath
	import rfpt_pkg::*;
#(
	parameter int TABLE_DEPTH  = 1024,
	parameter int CORDIC_STEPS = 24,
	parameter int FILL_W       = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [KIND_W-1:0] in_kind,
	input  logic [TS_W-1:0]   in_ts,
	input  logic [WORD_W-1:0] in_freq,
	input  logic [WORD_W-1:0] in_par0,
	input  logic [WORD_W-1:0] in_par1,
	input  logic [WORD_W-1:0] in_det,
	output logic [WORD_W-1:0] phase,
	output logic              found,
	output logic [FILL_W-1:0] fill
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = 36;

	logic [TS_W-1:0]   mem_time  [TABLE_DEPTH];
	logic [WORD_W-1:0] mem_per   [TABLE_DEPTH];
	logic [WORD_W-1:0] mem_phase [TABLE_DEPTH];

	kind_t             kind_q;
	logic [TS_W-1:0]   ts_q;
	logic [WORD_W-1:0] freq_q;
	logic [WORD_W-1:0] per_q;
	logic [WORD_W-1:0] ang_q;
	logic [WORD_W-1:0] phase_q;
	logic              found_q;
	logic [FILL_W-1:0] fill_q;
	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic [5:0]        it_q;
	logic              cbusy_q;
	logic [1:0]        quad_q;
	logic              zero_q;
	logic              load_ok_q;
	logic [FILL_W-1:0] idx_q;
	logic [TS_W-1:0]   t_prev_q, t_cur_q;
	logic [WORD_W-1:0] p_prev_q, ph_prev_q;
	logic [AW-1:0]     idx_w, idx_p, idx_c;

	// divider shared by period and query modulo
	logic              div_start;
	logic [DIV_W-1:0]  div_num;
	logic [WORD_W-1:0] div_den;
	logic              div_done;
	logic [DIV_W-1:0]  div_quot;
	logic [WORD_W-1:0] div_rem;

	assign div_start = cmd.div_start;
	assign div_num   = cmd.div_for_mod ? DIV_W'({ts_q - t_prev_q, 16'd0}) : PERIOD_NUM;
	assign div_den   = cmd.div_for_mod ? p_prev_q : freq_q;

	rfpt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .done(div_done), .quot(div_quot), .rem(div_rem)
	);

	// input vector selection and normalization
	logic signed [WORD_W:0] p0s, p1s, xs, ys;
	logic [WORD_W:0]        ax, ay, am;
	logic [5:0]             lz;
	always_comb begin
		p0s = {in_par0[WORD_W-1], in_par0};
		p1s = {in_par1[WORD_W-1], in_par1};
		if (!in_det[WORD_W-1]) begin
			ys = -p0s;
			xs = p1s;
		end else begin
			ys = p0s;
			xs = -p1s;
		end
		ax = xs[WORD_W] ? -xs : xs;
		ay = ys[WORD_W] ? -ys : ys;
		am = (ax > ay) ? ax : ay;
		lz = 6'd0;
		for (int b = 0; b <= WORD_W; b++)
			if (am[b])
				lz = (b >= 30) ? 6'd0 : 6'(30 - b);
	end

	logic signed [CW-1:0] dx, dy;
	assign dx = cy_q >>> it_q;
	assign dy = cx_q >>> it_q;

	logic [WORD_W-1:0] th;
	logic [WORD_W-1:0] ang_c;
	always_comb begin
		if (cz_q < 0)
			th = '0;
		else if (cz_q > (CW'(1) <<< 30))
			th = 32'h40000000;
		else
			th = cz_q[WORD_W-1:0];
		case (quad_q)
			2'd0:    ang_c = th;
			2'd1:    ang_c = 32'h80000000 - th;
			2'd2:    ang_c = 32'h80000000 + th;
			default: ang_c = 32'h0 - th;
		endcase
	end

	logic [63:0] prod;
	assign prod = ang_q * per_q;

	logic [WORD_W:0] sum;
	assign sum = {1'b0, ph_prev_q} + {1'b0, div_rem};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			cbusy_q <= 1'b0;
			it_q    <= '0;
		end else begin
			if (cmd.clear)
				fill_q <= '0;
			else if (cmd.store)
				fill_q <= fill_q + FILL_W'(1);
			if (cmd.cordic_start) begin
				cbusy_q <= 1'b1;
				it_q    <= '0;
			end else if (cbusy_q) begin
				it_q <= it_q + 6'd1;
				if (it_q == 6'(CORDIC_STEPS - 1))
					cbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q    <= kind_t'(in_kind);
			ts_q      <= in_ts;
			freq_q    <= in_freq;
			load_ok_q <= (in_det != '0) && (in_freq != '0) &&
				(fill_q < FILL_W'(TABLE_DEPTH));
			cx_q      <= CW'(ax) <<< lz;
			cy_q      <= CW'(ay) <<< lz;
			zero_q    <= (am == '0);
			quad_q    <= !xs[WORD_W] ? (!ys[WORD_W] ? 2'd0 : 2'd3)
				: (!ys[WORD_W] ? 2'd1 : 2'd2);
			phase_q   <= '0;
			found_q   <= 1'b0;
		end
		if (cmd.cordic_start)
			cz_q <= '0;
		else if (cbusy_q) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + CW'(atan_turns(it_q[4:0]));
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - CW'(atan_turns(it_q[4:0]));
			end
		end
		if (div_done && !cmd.div_for_mod && cmd.cordic_start)
			per_q <= (div_quot[DIV_W-1:WORD_W] != '0) ? '1 : div_quot[WORD_W-1:0];
		if (cmd.mul)
			ang_q <= zero_q ? '0 : ang_c;
		if (cmd.store) begin
			phase_q <= prod[63:32];
			found_q <= 1'b1;
			mem_time[idx_w]  <= ts_q;
			mem_per[idx_w]   <= per_q;
			mem_phase[idx_w] <= prod[63:32];
		end
		if (cmd.scan_clr)
			idx_q <= FILL_W'(1);
		else if (cmd.scan_adv)
			idx_q <= idx_q + FILL_W'(1);
		if (cmd.scan_rd) begin
			t_prev_q  <= mem_time[idx_p];
			p_prev_q  <= mem_per[idx_p];
			ph_prev_q <= mem_phase[idx_p];
		end
		if (cmd.scan_rd)
			t_cur_q <= mem_time[idx_c];
		if (cmd.wrap) begin
			phase_q <= (sum < {1'b0, p_prev_q}) ? sum[WORD_W-1:0]
				: WORD_W'(sum - {1'b0, p_prev_q});
			found_q <= 1'b1;
		end
		if (cmd.clear || cmd.miss) begin
			phase_q <= '0;
			found_q <= 1'b0;
		end
	end

	assign idx_w = fill_q[AW-1:0];
	assign idx_p = AW'(idx_q - FILL_W'(1));
	assign idx_c = idx_q[AW-1:0];

	assign sts.kind        = kind_q;
	assign sts.load_ok     = load_ok_q;
	assign sts.div_done    = div_done;
	assign sts.cordic_done = !cbusy_q;
	assign sts.scan_end    = (idx_q >= fill_q);
	assign sts.bracket     = (t_cur_q > ts_q) && (t_prev_q <= ts_q);

	assign phase = phase_q;
	assign found = found_q;
	assign fill  = fill_q;
endmodule

// ===== rtl/rfpt_ctrl.sv =====
module rfpt_ctrl
	import rfpt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_fire,
	input  sts_t sts,
	output cmd_t cmd,
	output logic in_rdy,
	output logic out_vld
);
	state_t state_q, state_d;
	logic   go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= (state_q == ST_IDLE && in_fire) || (state_q == ST_SCAN_CMP &&
				sts.bracket && !sts.scan_end);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (in_fire)
					state_d = ST_DIV;
			ST_DIV: begin
				// first cycle decodes the captured kind and issues its start or clear command
				if (go_q) begin
					case (sts.kind)
						KIND_LOAD:  state_d = sts.load_ok ? ST_DIV : ST_DONE;
						KIND_QUERY: state_d = ST_SCAN_RD;
						default:    state_d = ST_DONE;
					endcase
				end else if (sts.div_done)
					state_d = ST_CORDIC;
			end
			ST_CORDIC:
				if (sts.cordic_done && !go_q)
					state_d = ST_MUL;
			ST_MUL:      state_d = ST_STORE;
			ST_STORE:    state_d = ST_DONE;
			// stop before reading past the last stored entry
			ST_SCAN_RD:  state_d = sts.scan_end ? ST_DONE : ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (sts.bracket)
					state_d = ST_MOD;
				else
					state_d = ST_SCAN_RD;
			end
			ST_MOD:
				if (sts.div_done && !go_q)
					state_d = ST_WRAP;
			ST_WRAP:     state_d = ST_DONE;
			ST_DONE:
				if (out_fire)
					state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd     = '0;
		in_rdy  = 1'b0;
		out_vld = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_rdy      = 1'b1;
				cmd.capture = in_fire;
			end
			ST_DIV: begin
				if (go_q) begin
					cmd.div_start = (sts.kind == KIND_LOAD) && sts.load_ok;
					cmd.scan_clr  = 1'b1;
					cmd.clear     = (sts.kind == KIND_CLEAR);
				end
				cmd.cordic_start = !go_q && sts.div_done;
			end
			ST_MUL:   cmd.mul = 1'b1;
			ST_STORE: cmd.store = 1'b1;
			ST_SCAN_RD: cmd.scan_rd = !sts.scan_end;
			ST_SCAN_CMP: begin
				cmd.scan_adv    = !sts.bracket;
				cmd.div_start   = sts.bracket;
				cmd.div_for_mod = 1'b1;
			end
			ST_MOD:  cmd.div_for_mod = 1'b1;
			ST_WRAP: cmd.wrap = 1'b1;
			ST_DONE: out_vld = 1'b1;
			default: ;
		endcase
	end
endmodule

// ===== rtl/rf_phase_table_and_lookup_core.sv =====
// channel | group      | tdata fields (low bit up)                          | tuser
// input   | s_axis_*   | timestamp[41:0] rf_freq fit_par0 fit_par1 fit_det  | kind[1:0]
// output  | m_axis_*   | phase_ns[31:0] table_fill[42:32]                   | found
// A load runs the period divider and then the CORDIC loop, then multiplies and stores;
// a query reads the stored entries in turn until one brackets its timestamp, then
// takes the modulo in the shared divider and wraps the phase by the stored period.
// One item is in flight; the next is taken once the result has been delivered.
// Reset empties the table; stored entries need no clearing.
module rf_phase_table_and_lookup_core
	import rfpt_pkg::*;
#(
	parameter int TABLE_DEPTH  = 1024,
	parameter int CORDIC_STEPS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [175:0] s_axis_tdata,   // timestamp, rf_freq, fit_par0, fit_par1, fit_det
	input  logic [1:0]   s_axis_tuser,   // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [47:0]  m_axis_tdata,   // phase_ns, table_fill
	output logic         m_axis_tuser    // found
);
	localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

	cmd_t cmd;
	sts_t sts;
	logic in_fire, out_fire, in_rdy, out_vld;
	logic [WORD_W-1:0] phase;
	logic              found;
	logic [FILL_W-1:0] fill;

	assign in_fire  = s_axis_tvalid && in_rdy;
	assign out_fire = out_vld && m_axis_tready;

	rfpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .cmd(cmd), .in_rdy(in_rdy), .out_vld(out_vld)
	);

	rfpt_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH), .CORDIC_STEPS(CORDIC_STEPS), .FILL_W(FILL_W)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_kind(s_axis_tuser),
		.in_ts(s_axis_tdata[41:0]),
		.in_freq(s_axis_tdata[73:42]),
		.in_par0(s_axis_tdata[105:74]),
		.in_par1(s_axis_tdata[137:106]),
		.in_det(s_axis_tdata[169:138]),
		.phase(phase), .found(found), .fill(fill)
	);

	assign s_axis_tready = in_rdy;
	assign m_axis_tvalid = out_vld;
	assign m_axis_tdata  = {5'd0, 11'(fill), phase};
	assign m_axis_tuser  = found;

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= FILL_W'(TABLE_DEPTH)) else $error("fill beyond depth");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
endmodule

// ===== tb/rf_phase_table_and_lookup_core_tb.sv =====
`timescale 1ns / 100ps

module rf_phase_table_and_lookup_core_tb;
	import rfpt_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int STEPS      = 24;
	localparam int CYCLE_CAP  = 6000000;
	localparam int RAND_ITEMS = 540;
	localparam int LAST_LOADS = 40;

	typedef struct packed {
		logic [31:0] phase;
		logic        found;
		logic [10:0] fill;
	} rf_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [175:0] s_axis_tdata;   // timestamp, rf_freq, fit_par0, fit_par1, fit_det
	logic [1:0]   s_axis_tuser;   // kind
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [47:0]  m_axis_tdata;   // phase_ns, table_fill
	logic         m_axis_tuser;   // found

	rf_phase_table_and_lookup_core #(
		.TABLE_DEPTH (DEPTH),
		.CORDIC_STEPS(STEPS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// shadow of the record table
	logic [41:0] rec_time   [DEPTH];
	logic [31:0] rec_period [DEPTH];
	logic [31:0] rec_phase  [DEPTH];
	int          rec_count;

	rf_result_t pending_results[$];
	int error_count;
	int checked_count;
	int n_load, n_query, n_clear, n_other, n_stored, n_hit;
	bit quiet;
	longint unsigned cycle_count;

	localparam logic [31:0] ARC_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] vector_angle(longint x, longint y);
		longint ax, ay, m, cx, cy, z, dx, dy;
		logic [63:0] a;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		m  = (ax > ay) ? ax : ay;
		if (m == 0)
			return 32'd0;
		while (m < (64'sd1 <<< 30)) begin
			m = m <<< 1; ax = ax <<< 1; ay = ay <<< 1;
		end
		cx = ax; cy = ay; z = 0;
		for (int i = 0; i < STEPS && i < 32; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy > 0) begin
				cx += dx; cy -= dy; z += longint'(ARC_TURNS[i]);
			end else begin
				cx -= dx; cy += dy; z -= longint'(ARC_TURNS[i]);
			end
		end
		if (z < 0) z = 0;
		if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
		if (x >= 0 && y >= 0)
			a = z;
		else if (x < 0 && y >= 0)
			a = (64'd1 << 31) - z;
		else if (x < 0)
			a = (64'd1 << 31) + z;
		else
			a = (64'd1 << 32) - z;
		return a[31:0];
	endfunction

	function automatic rf_result_t predict_phase(kind_t k, logic [41:0] ts, logic [31:0] freq,
			logic signed [31:0] p0, logic signed [31:0] p1, logic signed [31:0] det);
		rf_result_t r;
		logic [63:0] per, ph, shift, prod;
		longint x, y;
		r = '0;
		case (k)
			KIND_LOAD: begin
				if (det != 0 && freq != 0 && rec_count < DEPTH) begin
					per = PERIOD_NUM / freq;
					if (per > 64'hFFFF_FFFF) per = 64'hFFFF_FFFF;
					if (det > 0) begin
						y = -longint'(p0); x = longint'(p1);
					end else begin
						y = longint'(p0); x = -longint'(p1);
					end
					prod = {32'd0, vector_angle(x, y)} * per;
					rec_time[rec_count]   = ts;
					rec_period[rec_count] = per[31:0];
					rec_phase[rec_count]  = prod[63:32];
					rec_count++;
					r.phase = prod[63:32];
					r.found = 1'b1;
				end
			end
			KIND_QUERY: begin
				for (int i = 1; i < rec_count; i++) begin
					if (rec_time[i] > ts && rec_time[i-1] <= ts) begin
						per = rec_period[i-1];
						ph  = rec_phase[i-1];
						shift = 0;
						if (per != 0)
							shift = ({22'd0, ts - rec_time[i-1]} << 16) % per;
						r.phase = (ph + shift < per) ? ph + shift : ph + shift - per;
						r.found = 1'b1;
						break;
					end
				end
			end
			KIND_CLEAR: rec_count = 0;
			default: ;
		endcase
		r.fill = 11'(rec_count);
		return r;
	endfunction

	task automatic send_req(kind_t k, logic [41:0] ts, logic [31:0] freq, logic [31:0] p0,
			logic [31:0] p1, logic [31:0] det, bit typed = 0, rf_result_t typed_res = '0);
		rf_result_t r;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= k;
		s_axis_tdata  <= {6'd0, det, p1, p0, freq, ts};
		do @(posedge clk); while (!s_axis_tready);
		r = predict_phase(k, ts, freq, p0, p1, det);
		pending_results = {pending_results, (typed ? typed_res : r)};
		case (k)
			KIND_LOAD: begin n_load++; n_stored += r.found; end
			KIND_QUERY: begin n_query++; n_hit += r.found; end
			KIND_CLEAR: n_clear++;
			default: n_other++;
		endcase
	endtask

	function automatic logic [41:0] rand_ts();
		return {10'($urandom_range(0, 1023)), $urandom};
	endfunction

	task automatic send_load(logic [41:0] ts);
		logic [31:0] freq, p0, p1, det;
		case ($urandom_range(0, 7))
			0: freq = 32'd0;
			1: freq = $urandom_range(1, 20480);
			default: freq = $urandom;
		endcase
		det = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
		p0 = $urandom;
		p1 = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			p0 = 0; p1 = 0;
		end
		send_req(KIND_LOAD, ts, freq, p0, p1, det);
	endtask

	// optional clear, a run of loads at rising times, then queries mostly inside the run
	task automatic run_sequence(int max_loads);
		logic [41:0] t, first;
		logic [63:0] span, off;
		int nl, nq;
		if ($urandom_range(0, 1))
			send_req(KIND_CLEAR, rand_ts(), $urandom, $urandom, $urandom, $urandom);
		t = rand_ts();
		if (t[41:40] == 2'b11) t[40] = 1'b0;
		first = t;
		nl = $urandom_range(1, max_loads);
		for (int i = 0; i < nl; i++) begin
			send_load(t);
			t += ($urandom_range(0, 2) == 0) ? $urandom_range(1, 1 << 30)
				: $urandom_range(1, 200000);
		end
		span = t - first;
		nq = $urandom_range(1, 10);
		for (int i = 0; i < nq; i++) begin
			off = {$urandom, $urandom} % (span + 2);
			send_req(KIND_QUERY, ($urandom_range(0, 4) == 0) ? rand_ts() : first + off,
				$urandom, $urandom, $urandom, $urandom);
		end
	endtask

	task automatic run_noise();
		kind_t k;
		repeat ($urandom_range(1, 4)) begin
			k = kind_t'(($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2));
			if (k == KIND_LOAD)
				send_load(rand_ts());
			else
				send_req(k, rand_ts(), $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	// result check
	always @(posedge clk) begin
		rf_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with none outstanding: phase_ns %h found %b table_fill %0d",
					m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[42:32]);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (m_axis_tdata[31:0] !== want.phase) begin
					$error("phase_ns expected %h actual %h", want.phase, m_axis_tdata[31:0]);
					error_count++;
				end
				if (m_axis_tuser !== want.found) begin
					$error("found expected %b actual %b", want.found, m_axis_tuser);
					error_count++;
				end
				if (m_axis_tdata[42:32] !== want.fill) begin
					$error("table_fill expected %0d actual %0d", want.fill, m_axis_tdata[42:32]);
					error_count++;
				end
			end
		end
	end

	// output back-pressure
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		arst_n        = 1'b0;
		cycle_count   = 0;
		error_count   = 0;
		checked_count = 0;
		rec_count     = 0;
		quiet         = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		send_req(KIND_QUERY, 42'd10, 0, 0, 0, 0, 1, '{32'd0, 1'b0, 11'd0});
		send_req(KIND_LOAD, 42'd5, 32'd100, 32'd1, 32'd1, 32'd0, 1, '{32'd0, 1'b0, 11'd0});
		send_req(KIND_LOAD, 42'd5, 32'd0, 32'd1, 32'd1, 32'd1, 1, '{32'd0, 1'b0, 11'd0});
		send_req(KIND_LOAD, 42'd0, 32'd1, 32'd0, 32'd0, 32'd1, 1, '{32'd0, 1'b1, 11'd1});
		send_req(KIND_LOAD, 42'd100, 32'd20480, 32'd7, 32'd3, 32'd9);
		send_req(KIND_LOAD, 42'd1000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000);
		send_req(KIND_QUERY, 42'd50, 0, 0, 0, 0);
		send_req(KIND_QUERY, 42'd0, 0, 0, 0, 0);
		send_req(KIND_QUERY, 42'd1000, 0, 0, 0, 0, 1, '{32'd0, 1'b0, 11'd3});
		send_req(KIND_QUERY, 42'd999, 0, 0, 0, 0);
		send_req(KIND_LOAD, 42'd5000, 32'd3000000, -32'sd5, 32'sd7, -32'sd3);
		send_req(KIND_LOAD, '1, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_req(KIND_QUERY, 42'h3FF_FFFF_FFFE, '1, '1, '1, '1);
		send_req(KIND_QUERY, 42'd4999, 0, 0, 0, 0);
		send_req(KIND_NONE, 42'd7, 32'd5, 32'd5, 32'd5, 32'd5, 1, '{32'd0, 1'b0, 11'd5});
		send_req(KIND_CLEAR, 42'd0, 0, 0, 0, 0, 1, '{32'd0, 1'b0, 11'd0});
		send_req(KIND_QUERY, 42'd100, 0, 0, 0, 0, 1, '{32'd0, 1'b0, 11'd0});
		send_req(KIND_LOAD, 42'd200, 32'h5000_0000, -32'sd1, 32'sd0, 32'sd1);
		send_req(KIND_LOAD, 42'd300, 32'd12345678, 32'sd0, -32'sd1, 32'sd1);
		send_req(KIND_QUERY, 42'd299, 0, 0, 0, 0);
		send_req(KIND_LOAD, 42'd400, 32'd77, 32'sd5, 32'h8000_0000, 32'sd3);
		send_req(KIND_LOAD, 42'd500, 32'd99, 32'h8000_0000, 32'sd9, -32'sd3);

		// random sequences
		while (n_load + n_query + n_clear + n_other < RAND_ITEMS - LAST_LOADS - 10) begin
			if (n_load + n_query + n_clear + n_other > RAND_ITEMS - 130)
				quiet = 1;
			if ($urandom_range(0, 4) == 0)
				run_noise();
			else
				run_sequence(12);
		end

		// a longer run at known spacing, then scan it end to end
		quiet = 1;
		send_req(KIND_CLEAR, 0, 0, 0, 0, 0);
		for (int i = 0; i < LAST_LOADS; i++)
			send_req(KIND_LOAD, 42'd1000 * i + $urandom_range(0, 999), $urandom | 32'd1,
				$urandom, $urandom, $urandom | 32'd1);
		send_req(KIND_QUERY, 42'd1000 * (LAST_LOADS - 1) - 1, 0, 0, 0, 0);
		send_req(KIND_QUERY, 42'd1000 * LAST_LOADS + 5000, 0, 0, 0, 0);
		send_req(KIND_QUERY, 42'd1500, 0, 0, 0, 0);
		send_req(KIND_CLEAR, 0, 0, 0, 0, 0);

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2200) @(posedge clk);

		$display("covered %0d loads (%0d stored), %0d queries (%0d bracketed), %0d clears",
			n_load, n_stored, n_query, n_hit, n_clear);
		$display("%0d ignored-kind requests, %0d results checked", n_other, checked_count);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rfpt_pkg.sv
rtl/rfpt_div.sv
rtl/rfpt_datapath.sv
rtl/rfpt_ctrl.sv
rtl/rf_phase_table_and_lookup_core.sv
tb/rf_phase_table_and_lookup_core_tb.sv
